// ----- hdl/amfd_pkg.sv -----
// shared types, register indexes and reset values for the motion and flip detector
package amfd_pkg;

   localparam int SampleWidth    = 16;
   localparam int DeltaWidth     = 18;
   localparam int RunWidth       = 4;
   localparam int CsrIndexWidth  = 2;
   localparam int CsrDataWidth   = 18;

   typedef logic signed [SampleWidth-1:0] sample_type;
   typedef logic [DeltaWidth-1:0]         delta_type;
   typedef logic [RunWidth-1:0]           run_type;

   // register indexes of the configuration port
   localparam logic [CsrIndexWidth-1:0] CSR_MOTION_THRESHOLD = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_FACE_DOWN_LEVEL  = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_FACE_UP_LEVEL    = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_FACE_DOWN_NEEDED = 2'd3;

   // 0.18 g, -0.65 g and 0.30 g at 4096 counts per g
   localparam delta_type  MOTION_THRESHOLD_RESET = 18'd737;
   localparam sample_type FACE_DOWN_LEVEL_RESET  = -16'sd2662;
   localparam sample_type FACE_UP_LEVEL_RESET    = 16'sd1229;
   localparam run_type    FACE_DOWN_NEEDED_RESET = 4'd4;

   typedef struct packed {
      sample_type down_level;
      sample_type up_level;
      run_type    needed;
   } flip_cfg_type;

   typedef struct packed {
      logic mute_request;
      logic unmute_request;
      logic muted;
   } flip_result_type;

endpackage

// ----- hdl/amfd_flip.sv -----
// face-down run counter and mute state
module amfd_flip
   import amfd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  sample_type      accel_z,
   input  flip_cfg_type    cfg,
   output flip_result_type result
);

   run_type run_ff, run_in;
   logic    mute_ff, mute_in;
   logic    face_down, face_up;

   always_comb begin
      face_down = accel_z < cfg.down_level;
      face_up   = accel_z > cfg.up_level;
      run_in    = run_ff;
      mute_in   = mute_ff;
      result.mute_request   = 1'b0;
      result.unmute_request = 1'b0;
      // face down wins when the two levels overlap
      if (face_down) begin
         if (run_ff < cfg.needed) begin
            run_in = run_ff + run_type'(1);
            if (run_in == cfg.needed && !mute_ff) begin
               mute_in = 1'b1;
               result.mute_request = 1'b1;
            end
         end
      end else if (face_up) begin
         run_in = '0;
         if (mute_ff) begin
            mute_in = 1'b0;
            result.unmute_request = 1'b1;
         end
      end
      result.muted = mute_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= '0;
         mute_ff <= 1'b0;
      end else if (step) begin
         run_ff  <= run_in;
         mute_ff <= mute_in;
      end
   end

endmodule

// ----- hdl/accel_motion_flip_detector_core.sv -----
// top level of the accelerometer motion and flip detector
// Takes one x/y/z sample per transaction and returns one result per sample. A sample
// passes an input register and then a result register, and a new sample is taken
// every cycle while the result side keeps up. The input and result registers hold
// one transaction each: while a result is stalled the input stalls as soon as the
// input register is occupied.
// The motion delta is the L1 distance to the previous sample (zero on the first one
// after reset); wake is raised when it exceeds the motion threshold. Configuration
// is written through csr_we/csr_index/csr_wdata and should only change while idle.
module accel_motion_flip_detector_core
   import amfd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [15:0]       req_accel_x,
   input  logic signed [15:0]       req_accel_y,
   input  logic signed [15:0]       req_accel_z,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_wake,
   output logic                     rsp_mute_request,
   output logic                     rsp_unmute_request,
   output logic                     rsp_muted,
   output logic [17:0]              rsp_motion_delta
);

   // configuration
   delta_type    threshold_ff;
   flip_cfg_type flip_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff           <= MOTION_THRESHOLD_RESET;
         flip_cfg_ff.down_level <= FACE_DOWN_LEVEL_RESET;
         flip_cfg_ff.up_level   <= FACE_UP_LEVEL_RESET;
         flip_cfg_ff.needed     <= FACE_DOWN_NEEDED_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MOTION_THRESHOLD: threshold_ff <= csr_wdata;
            CSR_FACE_DOWN_LEVEL:  flip_cfg_ff.down_level <= csr_wdata[SampleWidth-1:0];
            CSR_FACE_UP_LEVEL:    flip_cfg_ff.up_level <= csr_wdata[SampleWidth-1:0];
            CSR_FACE_DOWN_NEEDED: flip_cfg_ff.needed <= csr_wdata[RunWidth-1:0];
            default: ;
         endcase
      end
   end

   // input stage
   logic       in_valid_ff;
   sample_type x_ff, y_ff, z_ff;
   logic       out_ready;
   logic       advance;

   assign out_ready = !rsp_valid || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         x_ff <= req_accel_x;
         y_ff <= req_accel_y;
         z_ff <= req_accel_z;
      end
   end

   // previous sample
   logic       have_prev_ff;
   sample_type prev_x_ff, prev_y_ff, prev_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_z_ff    <= '0;
      end else if (advance) begin
         have_prev_ff <= 1'b1;
         prev_x_ff    <= x_ff;
         prev_y_ff    <= y_ff;
         prev_z_ff    <= z_ff;
      end
   end

   // l1 distance
   logic signed [SampleWidth:0] dx, dy, dz;
   logic [SampleWidth-1:0]      ax, ay, az;
   delta_type                   delta_in;
   logic                        wake_in;

   always_comb begin
      dx = {x_ff[SampleWidth-1], x_ff} - {prev_x_ff[SampleWidth-1], prev_x_ff};
      dy = {y_ff[SampleWidth-1], y_ff} - {prev_y_ff[SampleWidth-1], prev_y_ff};
      dz = {z_ff[SampleWidth-1], z_ff} - {prev_z_ff[SampleWidth-1], prev_z_ff};
      ax = dx[SampleWidth] ? SampleWidth'(-dx) : dx[SampleWidth-1:0];
      ay = dy[SampleWidth] ? SampleWidth'(-dy) : dy[SampleWidth-1:0];
      az = dz[SampleWidth] ? SampleWidth'(-dz) : dz[SampleWidth-1:0];
      if (have_prev_ff) begin
         delta_in = DeltaWidth'(ax) + DeltaWidth'(ay) + DeltaWidth'(az);
      end else begin
         delta_in = '0;
      end
      wake_in = delta_in > threshold_ff;
   end

   flip_result_type flip_result;

   amfd_flip u_flip (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .accel_z (z_ff),
      .cfg     (flip_cfg_ff),
      .result  (flip_result)
   );

   // result register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_wake           <= wake_in;
         rsp_mute_request   <= flip_result.mute_request;
         rsp_unmute_request <= flip_result.unmute_request;
         rsp_muted          <= flip_result.muted;
         rsp_motion_delta   <= delta_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hdl/amfd_checker.sv -----
// port-level checks for the motion and flip detector, bound to the top level
module amfd_checker
   import amfd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_wake,
   input logic        rsp_mute_request,
   input logic        rsp_unmute_request,
   input logic        rsp_muted,
   input logic [17:0] rsp_motion_delta
);

   // a stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_motion_delta) && $stable(rsp_muted))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mute_request |-> rsp_muted && !rsp_unmute_request)
      else $error("mute request without mute state");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unmute_request |-> !rsp_muted)
      else $error("unmute request while still muted");

   // the threshold is unsigned and the compare strict
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wake |-> rsp_motion_delta != '0)
      else $error("wake with zero motion delta");

endmodule

bind accel_motion_flip_detector_core amfd_checker u_amfd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_wake           (rsp_wake),
   .rsp_mute_request   (rsp_mute_request),
   .rsp_unmute_request (rsp_unmute_request),
   .rsp_muted          (rsp_muted),
   .rsp_motion_delta   (rsp_motion_delta)
);
